[hw/rtl/rcit_pkg.sv]
// ----------------------------------------------------------------------------
// rcit_pkg
// Shared types, field widths and codes of the reference-counted interning
// table: request operations, result status codes and the packed result word.
// ----------------------------------------------------------------------------
package rcit_pkg;

    // Field widths of the stream words
    localparam int OP_W        = 2;
    localparam int KEY_FIELD_W = 64;
    localparam int IDX_FIELD_W = 7;
    localparam int CNT_FIELD_W = 16;

    // s_tdata: key from bit 0, entry_index above it, padded to whole bytes
    localparam int S_KEY_LSB   = 0;
    localparam int S_EI_LSB    = KEY_FIELD_W;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 32;

    // Index value that means "no entry"
    localparam logic [IDX_FIELD_W-1:0] IDX_NONE = '1;

    typedef enum logic [OP_W-1:0] {
        OP_CACHE   = 2'd0,
        OP_ADDREF  = 2'd1,
        OP_RELEASE = 2'd2,
        OP_LOOKUP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_BADIDX = 2'd2,
        STAT_SAT    = 2'd3
    } status_t;

    // Result word, first member in the highest bits: idx sits at bit 0
    typedef struct packed {
        logic [CNT_FIELD_W-1:0] cnt;
        status_t                status;
        logic                   found;
        logic [IDX_FIELD_W-1:0] idx;
    } result_t;

    localparam int RES_W = $bits(result_t);

    function automatic result_t mk_res(input logic [IDX_FIELD_W-1:0] idx,
                                       input logic                   found,
                                       input status_t                status,
                                       input logic [CNT_FIELD_W-1:0] cnt);
        result_t r;
        r.idx    = idx;
        r.found  = found;
        r.status = status;
        r.cnt    = cnt;
        return r;
    endfunction

endpackage

[hw/rtl/rcit_ram.sv]
// ----------------------------------------------------------------------------
// rcit_ram
// Single-clock memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rcit_ram #(
    parameter int WIDTH = 81,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/refcounted_interning_table_core.sv]
// Steps after acceptance: addref / release run S_IREAD, S_ICHECK, S_UPDATE and S_FINISH;
//   an entry not in use skips S_UPDATE, an ignored or out-of-range index goes to S_FINISH.
// Cache and lookup scan from entry 0, one read per cycle; a hit runs S_UPDATE, S_FINISH,
//   a miss S_FINISH. One item at a time, the next taken the cycle after the result loads.
// Reset: aresetn low clears control state, then a clearing pass over every address
//   initialises the entry and free-list memories with s_tready low.
// ----------------------------------------------------------------------------
// refcounted_interning_table_core
// Deduplicating key table with per-entry reference counts and a LIFO free
// list, held in two synchronous memories and updated read-modify-write.
// ----------------------------------------------------------------------------
module refcounted_interning_table_core
    import rcit_pkg::*;
#(
    parameter int ENTRIES    = 64,
    parameter int KEY_BITS   = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata: [63:0] key, [70:64] entry_index, [71] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: [1:0] op
    input  logic [OP_W-1:0]      s_tuser,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // m_tdata: [6:0] result_index, [7] found, [9:8] status, [25:10] ref_count,
    //          [31:26] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int SCNT_W = IDX_W + 1;
    localparam int NF_W   = IDX_W + 1;   // {end-of-list flag, index}

    typedef struct packed {
        logic                  valid;
        logic [COUNT_BITS-1:0] cnt;
        logic [KEY_BITS-1:0]   key;
    } entry_t;

    localparam int ENT_W = $bits(entry_t);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_IREAD,
        S_ICHECK,
        S_UPDATE,
        S_FINISH
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t               state_reg;
    logic [IDX_W-1:0]     clr_addr_reg;
    op_t                  op_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [SCNT_W-1:0]    scan_addr_reg;
    logic                 chk_valid_reg;
    logic [IDX_W-1:0]     chk_addr_reg;
    entry_t               ent_reg;
    logic                 fh_null_reg;
    logic [IDX_W-1:0]     fh_idx_reg;
    result_t              res_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // ------------------------------------------------------------------
    // Memory ports
    // ------------------------------------------------------------------
    logic             ent_we, ent_re;
    logic [IDX_W-1:0] ent_waddr, ent_raddr;
    logic [ENT_W-1:0] ent_wdata, ent_rdata;
    entry_t           ent_rd;

    logic             nf_we;
    logic [IDX_W-1:0] nf_waddr;
    logic [NF_W-1:0]  nf_wdata, nf_rdata;

    // Entry memory: valid flag, reference count and key per entry
    rcit_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_ent_ram (
        .aclk  (aclk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // Free-list link memory, read continuously at the list head so the
    // successor is ready whenever a miss allocates
    rcit_ram #(
        .WIDTH (NF_W),
        .DEPTH (ENTRIES)
    ) u_nf_ram (
        .aclk  (aclk),
        .we    (nf_we),
        .waddr (nf_waddr),
        .wdata (nf_wdata),
        .re    (1'b1),
        .raddr (fh_idx_reg),
        .rdata (nf_rdata)
    );

    assign ent_rd = entry_t'(ent_rdata);

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    op_t                    in_op;
    logic [KEY_BITS-1:0]    in_key;
    logic [IDX_FIELD_W-1:0] in_ei;
    logic                   in_ei_none;
    logic                   in_ei_bad;

    assign in_op      = op_t'(s_tuser);
    assign in_key     = s_tdata[S_KEY_LSB +: KEY_BITS];
    assign in_ei      = s_tdata[S_EI_LSB +: IDX_FIELD_W];
    assign in_ei_none = (in_ei == IDX_NONE);
    // Negative other than "none", or past the end of the table
    assign in_ei_bad  = in_ei[IDX_FIELD_W-1]
                        || (int'(in_ei[IDX_FIELD_W-2:0]) >= ENTRIES);

    // ------------------------------------------------------------------
    // Scan control: one read issued per cycle, compared in the next cycle, not later
    // ------------------------------------------------------------------
    logic scan_done, scan_hit, scan_miss;

    assign scan_done = (scan_addr_reg == SCNT_W'(ENTRIES));
    assign scan_hit  = chk_valid_reg && ent_rd.valid && (ent_rd.key == key_reg);
    assign scan_miss = !chk_valid_reg && scan_done;

    // ------------------------------------------------------------------
    // Count update on the captured entry
    // ------------------------------------------------------------------
    logic [COUNT_BITS-1:0] cnt_inc, cnt_dec;
    logic                  cnt_max;
    logic                  upd_write;
    logic                  rel_zero;
    entry_t                upd_ent;
    result_t               upd_res;
    logic [IDX_FIELD_W-1:0] idx_out;

    assign cnt_max = &ent_reg.cnt;
    assign cnt_inc = ent_reg.cnt + COUNT_BITS'(1);
    assign cnt_dec = (ent_reg.cnt != '0) ? ent_reg.cnt - COUNT_BITS'(1) : '0;
    assign idx_out = IDX_FIELD_W'(idx_reg);

    always_comb begin
        upd_write = 1'b0;
        rel_zero  = 1'b0;
        upd_ent   = ent_reg;
        upd_res   = mk_res(idx_out, 1'b1, STAT_OK, CNT_FIELD_W'(ent_reg.cnt));
        case (op_reg)
            OP_LOOKUP: begin
                upd_res = mk_res(idx_out, 1'b1, STAT_OK, CNT_FIELD_W'(ent_reg.cnt));
            end
            OP_CACHE, OP_ADDREF: begin
                // Hold a saturated count and flag it
                if (cnt_max) begin
                    upd_res = mk_res(idx_out, op_reg == OP_CACHE, STAT_SAT,
                                     CNT_FIELD_W'(ent_reg.cnt));
                end else begin
                    upd_write   = 1'b1;
                    upd_ent.cnt = cnt_inc;
                    upd_res     = mk_res(idx_out, op_reg == OP_CACHE, STAT_OK,
                                         CNT_FIELD_W'(cnt_inc));
                end
            end
            OP_RELEASE: begin
                // Drop the count; at zero invalidate and push onto the free list
                upd_write     = 1'b1;
                rel_zero      = (cnt_dec == '0);
                upd_ent.cnt   = cnt_dec;
                upd_ent.valid = (cnt_dec != '0);
                upd_res       = mk_res(idx_out, 1'b0, STAT_OK, CNT_FIELD_W'(cnt_dec));
            end
            default: begin
                upd_write = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Memory access steering
    // ------------------------------------------------------------------
    always_comb begin
        ent_we    = 1'b0;
        ent_waddr = idx_reg;
        ent_wdata = ENT_W'(upd_ent);
        ent_re    = 1'b0;
        ent_raddr = idx_reg;
        nf_we     = 1'b0;
        nf_waddr  = idx_reg;
        nf_wdata  = {fh_null_reg, fh_idx_reg};
        case (state_reg)
            S_CLEAR: begin
                ent_we    = 1'b1;
                ent_waddr = clr_addr_reg;
                ent_wdata = '0;
                nf_we     = 1'b1;
                nf_waddr  = clr_addr_reg;
                if (clr_addr_reg == IDX_W'(ENTRIES - 1)) begin
                    nf_wdata = {1'b1, {IDX_W{1'b0}}};
                end else begin
                    nf_wdata = {1'b0, clr_addr_reg + IDX_W'(1)};
                end
            end
            S_SCAN: begin
                ent_re    = !scan_done;
                ent_raddr = scan_addr_reg[IDX_W-1:0];
                // Miss on a cache request: take the free-list head
                if (!scan_hit && scan_miss && op_reg == OP_CACHE && !fh_null_reg) begin
                    ent_we    = 1'b1;
                    ent_waddr = fh_idx_reg;
                    ent_wdata = {1'b1, COUNT_BITS'(1), key_reg};
                end
            end
            S_IREAD: begin
                ent_re = 1'b1;
            end
            S_UPDATE: begin
                ent_we = upd_write;
                nf_we  = rel_zero;
            end
            default: begin
                ent_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer and output register
    // Each item finishes its write-back before the next is accepted, so a
    // read never meets a pending write to the same entry.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            scan_addr_reg <= '0;
            chk_valid_reg <= 1'b0;
            fh_null_reg   <= 1'b0;
            fh_idx_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            // Drop a taken result word unless S_FINISH loads the next one
            if (m_tready && state_reg != S_FINISH) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + IDX_W'(1);
                    if (clr_addr_reg == IDX_W'(ENTRIES - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg  <= in_op;
                        key_reg <= in_key;
                        idx_reg <= IDX_W'(in_ei[IDX_FIELD_W-2:0]);
                        if (in_op == OP_CACHE || in_op == OP_LOOKUP) begin
                            scan_addr_reg <= '0;
                            chk_valid_reg <= 1'b0;
                            state_reg     <= S_SCAN;
                        end else if (in_ei_none) begin
                            res_reg   <= mk_res(IDX_NONE, 1'b0, STAT_OK, '0);
                            state_reg <= S_FINISH;
                        end else if (in_ei_bad) begin
                            res_reg   <= mk_res(IDX_NONE, 1'b0, STAT_BADIDX, '0);
                            state_reg <= S_FINISH;
                        end else begin
                            state_reg <= S_IREAD;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        ent_reg   <= ent_rd;
                        idx_reg   <= chk_addr_reg;
                        state_reg <= S_UPDATE;
                    end else if (scan_miss) begin
                        if (op_reg == OP_LOOKUP) begin
                            res_reg <= mk_res(IDX_NONE, 1'b0, STAT_OK, '0);
                        end else if (fh_null_reg) begin
                            res_reg <= mk_res(IDX_NONE, 1'b0, STAT_FULL, '0);
                        end else begin
                            fh_null_reg <= nf_rdata[NF_W-1];
                            fh_idx_reg  <= nf_rdata[IDX_W-1:0];
                            res_reg     <= mk_res(IDX_FIELD_W'(fh_idx_reg), 1'b0,
                                                  STAT_OK, CNT_FIELD_W'(1));
                        end
                        state_reg <= S_FINISH;
                    end else begin
                        chk_valid_reg <= !scan_done;
                        chk_addr_reg  <= scan_addr_reg[IDX_W-1:0];
                        if (!scan_done) begin
                            scan_addr_reg <= scan_addr_reg + SCNT_W'(1);
                        end
                    end
                end
                S_IREAD: begin
                    state_reg <= S_ICHECK;
                end
                S_ICHECK: begin
                    if (!ent_rd.valid) begin
                        res_reg   <= mk_res(IDX_NONE, 1'b0, STAT_BADIDX, '0);
                        state_reg <= S_FINISH;
                    end else begin
                        ent_reg   <= ent_rd;
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    res_reg <= upd_res;
                    if (rel_zero) begin
                        fh_null_reg <= 1'b0;
                        fh_idx_reg  <= idx_reg;
                    end
                    state_reg <= S_FINISH;
                end
                S_FINISH: begin
                    // Load the result once the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {{(M_TDATA_W - RES_W){1'b0}}, res_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[hw/rtl/rcit_checker.sv]
// ----------------------------------------------------------------------------
// rcit_checker
// Port-level assertions for the interning table core, bound into the core module.
// ----------------------------------------------------------------------------
module rcit_checker
    import rcit_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    result_t r;

    assign r = result_t'(m_tdata[RES_W-1:0]);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // One item in flight: no acceptance right after an acceptance
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while one is in flight");

    // A full table allocates nothing
    a_full_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.status == STAT_FULL |->
            r.idx == IDX_NONE && r.cnt == '0 && !r.found)
        else $error("table-full result carries an entry");

    // Found only on a successful or saturated hit
    a_found_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.found |-> r.status == STAT_OK || r.status == STAT_SAT)
        else $error("found set with an error status");

    // No entry means no count
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (ENTRIES < 128) && m_tvalid && r.idx == IDX_NONE |->
            r.cnt == '0 && !r.found)
        else $error("count or found reported without an entry");

endmodule

bind refcounted_interning_table_core rcit_checker #(
    .ENTRIES (ENTRIES)
) u_rcit_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
